@@ hw/rtl/bole_pkg.sv @@
// Shared constants and types for the bounded ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 4;
  localparam int USED_W = 5;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_CONTAINS = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_COUNT    = 3'd5,
    CMD_GET      = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

@@ hw/rtl/bounded_ordered_list_engine.sv @@
// Bounded ordered list engine: circular entry memory with head pointer and count.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  in_command, in_value, in_position
//   out_     output     out_valid/out_ready out_data, out_found, out_entries_used, out_status
//
// Push, clear, count and every error case load the result straight from idle; pop and get
// read the entry via ST_READ. Contains scans from the head to a match or the end; delete
// scans the same way and, on a match, shifts every later entry one place towards the head.
// The single read port reads one entry per cycle. Reset clears the state, count, head,
// pending flag and result valid; the entry memory needs no clearing pass. A new command
// is taken only in idle, and only when the result register is empty or being drained.
`timescale 1ns / 1ps

module bounded_ordered_list_engine
  import bole_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_found,
  output logic [USED_W-1:0]        out_entries_used,
  output logic [STAT_W-1:0]        out_status
);

  // entry memory
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  rd_lidx_r, rd_lidx_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  pend_lidx_r, pend_lidx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_found_r, out_found_nxt;
  logic [USED_W-1:0] out_used_r, out_used_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_load;

  logic              accept;
  logic [PTR_W-1:0]  head_inc, head_dec;

  // physical slot of a logical position counted from the head
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] h,
                                            input logic [CNT_W-1:0] l);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(l);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return PTR_W'(s);
  endfunction

  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - 1'b1;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    rd_lidx_nxt    = rd_lidx_r;
    pend_nxt       = pend_r;
    pend_lidx_nxt  = pend_lidx_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = rd_data_r;
    mem_re         = 1'b0;
    mem_raddr      = head_r;
    out_load       = 1'b0;
    out_data_nxt   = '0;
    out_found_nxt  = 1'b0;
    out_status_nxt = STAT_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_command);
          val_nxt = in_value;
          unique case (cmd_t'(in_command))
            CMD_PUSH: begin
              out_load = 1'b1;
              if (cnt_r == CNT_W'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                mem_wdata = in_value;
                head_nxt  = head_dec;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            CMD_POP: begin
              if (cnt_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = ST_READ;
              end
            end
            CMD_CONTAINS, CMD_DELETE: begin
              if (cnt_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = (cmd_t'(in_command) == CMD_DELETE) ? STAT_EMPTY : STAT_OK;
              end else begin
                rd_lidx_nxt = '0;
                pend_nxt    = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt  = '0;
              out_load = 1'b1;
            end
            CMD_GET: begin
              if (32'(in_position) >= 32'(cnt_r)) begin
                out_load       = 1'b1;
                out_status_nxt = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = phys(head_r, CNT_W'(in_position));
                state_nxt = ST_READ;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_load     = 1'b1;
        out_data_nxt = rd_data_r;
        if (cmd_r == CMD_POP) begin
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        if (pend_r && (rd_data_r == val_r)) begin
          if (cmd_r == CMD_CONTAINS) begin
            out_load      = 1'b1;
            out_found_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            // close the gap: pull every later entry one place towards the head
            rd_lidx_nxt = pend_lidx_r + 1'b1;
            pend_nxt    = 1'b0;
            state_nxt   = ST_SHIFT;
          end
        end else if (rd_lidx_r < cnt_r) begin
          mem_re        = 1'b1;
          mem_raddr     = phys(head_r, rd_lidx_r);
          rd_lidx_nxt   = rd_lidx_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_lidx_nxt = rd_lidx_r;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_r, pend_lidx_r - 1'b1);
          mem_wdata = rd_data_r;
        end
        if (rd_lidx_r < cnt_r) begin
          mem_re        = 1'b1;
          mem_raddr     = phys(head_r, rd_lidx_r);
          rd_lidx_nxt   = rd_lidx_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_lidx_nxt = rd_lidx_r;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cnt_nxt       = cnt_r - 1'b1;
            out_load      = 1'b1;
            out_found_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_used_nxt  = USED_W'(cnt_nxt);
    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    rd_lidx_r   <= rd_lidx_nxt;
    pend_lidx_r <= pend_lidx_nxt;
    if (out_load) begin
      out_data_r   <= out_data_nxt;
      out_found_r  <= out_found_nxt;
      out_used_r   <= out_used_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = signed'(out_data_r);
  assign out_found        = out_found_r;
  assign out_entries_used = out_used_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result held while a command is in progress");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_PUSH) && (cnt_r != CNT_W'(DEPTH)))
      |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("push did not advance the count");

  a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && state_nxt == ST_IDLE) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("delete did not drop the count");
`endif

endmodule

@@ tb/sv/bole_list_checker.sv @@
// Result checker for the bounded ordered list engine: list predictor and scoreboard.
`timescale 1ns / 1ps

module bole_list_checker
  import bole_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_data,
  input  logic                     out_found,
  input  logic [USED_W-1:0]        out_entries_used,
  input  logic [STAT_W-1:0]        out_status,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic [USED_W-1:0]        used;
    status_t                  status;
  } list_result_t;

  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_len = 0;
  list_result_t             result_q [$];
  int                       mismatches = 0;
  list_result_t             want;
  list_result_t             fresh;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] seen,
                                 input logic [DATA_W-1:0] wanted);
    $display("[%0t] %s: got %0h, want %0h", $realtime, what, seen, wanted);
    mismatches++;
  endtask

  // Close the gap left by the entry at slot
  task automatic drop_slot(input int slot);
    int k;
    for (k = slot; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
    list_len--;
  endtask

  task automatic list_apply(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                            input logic [POS_W-1:0] p, output list_result_t r);
    int k;
    int hit;
    r = '0;
    hit = -1;
    case (c)
      CMD_PUSH: begin
        if (list_len >= DEPTH) r.status = STAT_FULL;
        else begin
          for (k = list_len; k > 0; k--) list_mem[k] = list_mem[k - 1];
          list_mem[0] = v;
          list_len++;
        end
      end
      CMD_POP: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else begin
          r.data = list_mem[0];
          drop_slot(0);
        end
      end
      CMD_CONTAINS: begin
        for (k = 0; k < list_len; k++)
          if (hit < 0 && list_mem[k] == v) hit = k;
        r.found = (hit >= 0);
      end
      CMD_DELETE: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else begin
          for (k = 0; k < list_len; k++)
            if (hit < 0 && list_mem[k] == v) hit = k;
          if (hit >= 0) begin
            r.found = 1'b1;
            drop_slot(hit);
          end
        end
      end
      CMD_CLEAR: list_len = 0;
      CMD_GET: begin
        if (int'(p) >= list_len) r.status = STAT_RANGE;
        else r.data = list_mem[p];
      end
      default: ;
    endcase
    r.used = USED_W'(list_len);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      result_q.delete();
      list_len = 0;
    end else begin
      // Retire the drained result before queueing a new transaction
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_data, '0);
        end else begin
          want = result_q.pop_front();
          if (out_data !== want.data)
            report_mismatch("data", out_data, want.data);
          if (out_found !== want.found)
            report_mismatch("found", out_found, want.found);
          if (out_entries_used !== want.used)
            report_mismatch("entries_used", out_entries_used, want.used);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
        end
      end
      if (in_valid && in_ready) begin
        list_apply(in_command, in_value, in_position, fresh);
        result_q.push_back(fresh);
      end
    end
    pending <= result_q.size();
  end

endmodule

@@ tb/sv/tb_bounded_ordered_list_engine.sv @@
// Testbench top for the bounded ordered list engine: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 60;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_command = CMD_COUNT;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_found;
  logic [USED_W-1:0]        out_entries_used;
  logic [STAT_W-1:0]        out_status;

  int fails;
  int pending;
  int cycles = 0;
  int rx_hold = 0;
  int rx_draw;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  logic signed [DATA_W-1:0] value_pool [8];

  bounded_ordered_list_engine uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_value, .in_position,
    .out_valid, .out_ready, .out_data, .out_found, .out_entries_used, .out_status
  );

  bole_list_checker chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_value, .in_position,
    .out_valid, .out_ready, .out_data, .out_found, .out_entries_used, .out_status,
    .fail_count(fails), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: after each drained transaction may hold ready low for a random stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        rx_draw = rx_calm ? 0 : $urandom_range(0, 7);
        if (rx_draw != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_draw;
        end
      end
    end else if (rx_hold <= 1) begin
      out_ready <= 1'b1;
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  // Keep valid high across back-to-back transactions; drop it only for a gap
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                          input logic [POS_W-1:0] p);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= c;
    in_value    <= v;
    in_position <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input int mix);
    int lim [7];
    int roll;
    int k;
    logic [CMD_W-1:0] order [8];
    order = '{CMD_PUSH, CMD_POP, CMD_DELETE, CMD_CONTAINS, CMD_GET, CMD_COUNT,
              CMD_CLEAR, CMD_UNUSED};
    case (mix)
      0:       lim = '{60, 70, 78, 86, 94, 97, 98};
      1:       lim = '{20, 45, 70, 80, 92, 96, 98};
      default: lim = '{35, 45, 55, 72, 92, 96, 97};
    endcase
    roll = $urandom_range(0, 99);
    for (k = 0; k < 7; k++)
      if (roll < lim[k]) return order[k];
    return order[7];
  endfunction

  // Mostly reuse a small set of values so that searches and deletes hit
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    int sent;
    int span;
    int mix;
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Commands on an empty list
    send_cmd(CMD_COUNT, 0, 0);
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_DELETE, 32'sd5, 0);
    send_cmd(CMD_CONTAINS, 32'sd5, 0);
    send_cmd(CMD_GET, 0, 4'd0);
    // Value extremes, then reads at and past the tail
    send_cmd(CMD_PUSH, 32'sh8000_0000, 0);
    send_cmd(CMD_PUSH, 32'sh7fff_ffff, 0);
    send_cmd(CMD_PUSH, 0, 0);
    send_cmd(CMD_PUSH, -32'sd1, 4'd15);
    send_cmd(CMD_CONTAINS, 32'sh7fff_ffff, 0);
    send_cmd(CMD_CONTAINS, 32'sd12345, 0);
    send_cmd(CMD_GET, 0, 4'd0);
    send_cmd(CMD_GET, 0, 4'd3);
    send_cmd(CMD_GET, 0, 4'd4);
    send_cmd(CMD_GET, 0, 4'd15);
    // Delete: miss, head, tail
    send_cmd(CMD_DELETE, 32'sd12345, 0);
    send_cmd(CMD_DELETE, -32'sd1, 0);
    send_cmd(CMD_DELETE, 32'sh8000_0000, 0);
    send_cmd(CMD_UNUSED, 32'sh7fff_ffff, 4'd15);
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_COUNT, 0, 0);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) drain_results();
      mix     = $urandom_range(0, 2);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 8; k++) value_pool[k] = $urandom;
      if ($urandom_range(0, 2) == 0) value_pool[0] = 32'sh8000_0000;
      if ($urandom_range(0, 2) == 0) value_pool[1] = 32'sh7fff_ffff;
      span = $urandom_range(30, 90);
      for (k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        send_cmd(pick_command(mix), pick_value(), POS_W'($urandom_range(0, 15)));
        sent++;
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
